// ===== rtl/average_then_running_median_filter_defines.svh =====
// Assertion macros for the frame-time smoother.
`ifndef AVERAGE_THEN_RUNNING_MEDIAN_FILTER_DEFINES_SVH
`define AVERAGE_THEN_RUNNING_MEDIAN_FILTER_DEFINES_SVH

`ifndef NO_ASSERTIONS
// Same-cycle implication, disabled during reset.
`define ATRM_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication, disabled during reset.
`define ATRM_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);
`else
`define ATRM_ASSERT_NOW(label, clk, rst, ante, cons, msg)
`define ATRM_ASSERT_NEXT(label, clk, rst, ante, cons, msg)
`endif

`endif

// ===== rtl/atrm_pkg.sv =====
package atrm_pkg;

  localparam int SAMPLE_W = 24;
  localparam int AVG_WIN  = 8;
  localparam int MED_WIN  = 100;

  localparam int APOS_W  = (AVG_WIN > 1) ? $clog2(AVG_WIN) : 1;
  localparam int AFILL_W = $clog2(AVG_WIN + 1);
  localparam int SUM_W   = SAMPLE_W + $clog2(AVG_WIN) + 1;
  localparam int REM_W   = AFILL_W + 1;
  localparam int DCNT_W  = $clog2(SUM_W + 1);

  localparam int MADDR_W = (MED_WIN > 1) ? $clog2(MED_WIN) : 1;
  localparam int MFILL_W = $clog2(MED_WIN + 1);
  localparam int AGE_W   = (MED_WIN > 1) ? $clog2(MED_WIN) : 1;

  typedef struct packed {
    logic [SAMPLE_W-1:0] value;
    logic [AGE_W-1:0]    age;
  } med_entry_t;

  localparam int ENTRY_W = $bits(med_entry_t);

endpackage

// ===== rtl/atrm_ram.sv =====
module atrm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                     clk,
  input  logic                                     we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                         wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/average_then_running_median_filter.sv =====
// Channel   Direction  Handshake                    Payload
// frame     in         frame_valid / frame_stall    frame_time    (24 bit unsigned)
// filtered  out        filtered_valid / filtered_stall filtered_time (24 bit unsigned)
//
// One request runs through these steps, where n is the number of held means
// (at most 100): accept, subtract, 28 divide steps, then for each of the n stored
// means a registered read of the median store and a processing step, one more
// step when the new mean goes in ahead of a stored one, and two steps to close.
// Reset is synchronous and clears only control state; store contents are unused
// until written. A result still held by filtered_stall keeps the block in its last step.
`include "average_then_running_median_filter_defines.svh"

module average_then_running_median_filter (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          frame_valid,
  output logic                          frame_stall,
  input  logic [atrm_pkg::SAMPLE_W-1:0] frame_time,
  output logic                          filtered_valid,
  input  logic                          filtered_stall,
  output logic [atrm_pkg::SAMPLE_W-1:0] filtered_time
);

  // Sequencer states.
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_SUB  = 3'd1;
  localparam logic [2:0] S_DIV  = 3'd2;
  localparam logic [2:0] S_READ = 3'd3;
  localparam logic [2:0] S_PROC = 3'd4;
  localparam logic [2:0] S_FIN  = 3'd5;
  localparam logic [2:0] S_OUT  = 3'd6;

  logic [2:0] state;

  // Moving-average state. The ring is read only at the write position.
  logic [atrm_pkg::SAMPLE_W-1:0] ring [atrm_pkg::AVG_WIN];
  logic [atrm_pkg::APOS_W-1:0]   apos;
  logic [atrm_pkg::AFILL_W-1:0]  afill;
  logic [atrm_pkg::SUM_W-1:0]    asum;
  logic [atrm_pkg::SAMPLE_W-1:0] drop_val;

  // Restoring divider: quotient bits shift into quo as the dividend
  // shifts out, one bit per cycle.
  logic [atrm_pkg::SUM_W-1:0]  quo;
  logic [atrm_pkg::REM_W-1:0]  rem;
  logic [atrm_pkg::DCNT_W-1:0] dcnt;
  logic [atrm_pkg::REM_W-1:0]  rem_sh;
  logic                        div_ge;

  // Running-median state. The sorted store lives in two banks: each request
  // reads the old list from one bank and writes the new list into the other.
  logic                         bank;
  logic [atrm_pkg::MFILL_W-1:0] mfill;
  logic [atrm_pkg::MFILL_W-1:0] newfill;
  logic [atrm_pkg::MFILL_W-1:0] midx;
  logic [atrm_pkg::MFILL_W-1:0] rptr;
  logic [atrm_pkg::MFILL_W-1:0] wptr;
  logic                         full;
  logic                         inserted;
  logic [atrm_pkg::SAMPLE_W-1:0] med_val;
  logic [atrm_pkg::SAMPLE_W-1:0] mean;

  atrm_pkg::med_entry_t rd_entry;
  atrm_pkg::med_entry_t wr_entry;
  atrm_pkg::med_entry_t new_entry;
  logic [atrm_pkg::ENTRY_W-1:0] rdata0;
  logic [atrm_pkg::ENTRY_W-1:0] rdata1;
  logic                         we;
  logic                         skip;
  logic                         ins_now;
  logic                         last_read;

  logic frame_acc;
  logic out_free;

  assign frame_stall = (state != S_IDLE);
  assign frame_acc   = frame_valid && !frame_stall;
  assign out_free    = !filtered_valid || !filtered_stall;

  assign rem_sh = {rem[atrm_pkg::REM_W-2:0], quo[atrm_pkg::SUM_W-1]};
  assign div_ge = (rem_sh >= {1'b0, afill});

  assign mean            = quo[atrm_pkg::SAMPLE_W-1:0];
  assign new_entry.value = mean;
  assign new_entry.age   = '0;

  atrm_ram #(
    .WIDTH(atrm_pkg::ENTRY_W),
    .DEPTH(atrm_pkg::MED_WIN)
  ) u_bank0 (
    .clk  (clk),
    .we   (we && bank),
    .waddr(wptr[atrm_pkg::MADDR_W-1:0]),
    .wdata(wr_entry),
    .raddr(rptr[atrm_pkg::MADDR_W-1:0]),
    .rdata(rdata0)
  );

  atrm_ram #(
    .WIDTH(atrm_pkg::ENTRY_W),
    .DEPTH(atrm_pkg::MED_WIN)
  ) u_bank1 (
    .clk  (clk),
    .we   (we && !bank),
    .waddr(wptr[atrm_pkg::MADDR_W-1:0]),
    .wdata(wr_entry),
    .raddr(rptr[atrm_pkg::MADDR_W-1:0]),
    .rdata(rdata1)
  );

  assign rd_entry = bank ? rdata1 : rdata0;

  // When the store is full, the oldest entry carries the largest possible age
  // and is dropped as it streams past. The new mean goes in front of the first
  // stored value that is strictly greater, which keeps it above equal values.
  assign skip      = full && (rd_entry.age == atrm_pkg::AGE_W'(atrm_pkg::MED_WIN - 1));
  assign ins_now   = !inserted && (rd_entry.value > mean);
  assign last_read = (rptr + 1'b1 == mfill);

  always_comb begin
    we       = 1'b0;
    wr_entry = new_entry;
    unique case (state)
      S_PROC: begin
        if (skip) begin
          we = 1'b0;
        end else if (ins_now) begin
          we = 1'b1;
        end else begin
          we             = 1'b1;
          wr_entry.value = rd_entry.value;
          wr_entry.age   = rd_entry.age + 1'b1;
        end
      end
      S_FIN: begin
        we = !inserted;
      end
      default: begin
        we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (frame_acc) begin
      ring[apos] <= frame_time;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      apos           <= '0;
      afill          <= '0;
      asum           <= '0;
      bank           <= 1'b0;
      mfill          <= '0;
      filtered_valid <= 1'b0;
    end else begin
      // The result register loads from the last sequencer step and empties
      // when its result is taken.
      if (state == S_OUT && out_free) begin
        filtered_valid <= 1'b1;
      end else if (filtered_valid && !filtered_stall) begin
        filtered_valid <= 1'b0;
      end
      // Capture the entry written at the median rank of the new list.
      if (we && (wptr == midx)) begin
        med_val <= wr_entry.value;
      end
      unique case (state)
        S_IDLE: begin
          if (frame_acc) begin
            if (afill == atrm_pkg::AFILL_W'(atrm_pkg::AVG_WIN)) begin
              drop_val <= ring[apos];
            end else begin
              drop_val <= '0;
              afill    <= afill + 1'b1;
            end
            asum <= asum + atrm_pkg::SUM_W'(frame_time);
            if (apos == atrm_pkg::APOS_W'(atrm_pkg::AVG_WIN - 1)) begin
              apos <= '0;
            end else begin
              apos <= apos + 1'b1;
            end
            state <= S_SUB;
          end
        end
        S_SUB: begin
          asum  <= asum - atrm_pkg::SUM_W'(drop_val);
          quo   <= asum - atrm_pkg::SUM_W'(drop_val);
          rem   <= '0;
          dcnt  <= '0;
          state <= S_DIV;
        end
        S_DIV: begin
          rem  <= div_ge ? (rem_sh - {1'b0, afill}) : rem_sh;
          quo  <= {quo[atrm_pkg::SUM_W-2:0], div_ge};
          dcnt <= dcnt + 1'b1;
          if (dcnt == atrm_pkg::DCNT_W'(atrm_pkg::SUM_W - 1)) begin
            full     <= (mfill == atrm_pkg::MFILL_W'(atrm_pkg::MED_WIN));
            rptr     <= '0;
            wptr     <= '0;
            inserted <= 1'b0;
            if (mfill == atrm_pkg::MFILL_W'(atrm_pkg::MED_WIN)) begin
              newfill <= mfill;
              midx    <= mfill >> 1;
            end else begin
              newfill <= mfill + 1'b1;
              midx    <= (mfill + 1'b1) >> 1;
            end
            state <= (mfill == '0) ? S_FIN : S_READ;
          end
        end
        S_READ: begin
          state <= S_PROC;
        end
        S_PROC: begin
          if (skip) begin
            rptr  <= rptr + 1'b1;
            state <= last_read ? S_FIN : S_READ;
          end else if (ins_now) begin
            // Hold the fetched entry; it is written on the next cycle.
            wptr     <= wptr + 1'b1;
            inserted <= 1'b1;
          end else begin
            wptr  <= wptr + 1'b1;
            rptr  <= rptr + 1'b1;
            state <= last_read ? S_FIN : S_READ;
          end
        end
        S_FIN: begin
          inserted <= 1'b1;
          mfill    <= newfill;
          bank     <= !bank;
          state    <= S_OUT;
        end
        S_OUT: begin
          if (out_free) begin
            filtered_time <= med_val;
            state         <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // A new request always starts the sum update.
  `ATRM_ASSERT_NEXT(a_accept_starts, clk, rst, frame_acc, state == S_SUB, "accept did not start")
  // The walk never fetches beyond the held list.
  `ATRM_ASSERT_NOW(a_read_in_list, clk, rst, state == S_PROC, rptr < mfill, "read past list")
  // Writes run at most one entry ahead of reads, so the new list stays ordered.
  `ATRM_ASSERT_NOW(a_write_near_read, clk, rst, state == S_PROC, wptr <= rptr + 1'b1, "write ran ahead")
  // The last step holds while the result register is not free.
  `ATRM_ASSERT_NEXT(a_out_load, clk, rst, state == S_OUT && !out_free, state == S_OUT, "result dropped")

endmodule

// ===== tb/sv/average_then_running_median_filter_tb.sv =====
module average_then_running_median_filter_tb;
  timeunit 1ns;
  timeprecision 1ps;

  // The block walks its median store through one read port, so the work for
  // a request grows with the number of held means.
  localparam int ITEM_CYCLES = 2 * atrm_pkg::MED_WIN + 32;
  // Quiet time after the last expected result, to catch late extra results.
  localparam int DRAIN_CYCLES = 4 * ITEM_CYCLES;
  // Length of the long receiver hold-off, several requests' worth of work.
  localparam int HOLD_CYCLES = 3 * ITEM_CYCLES;
  // The limit leaves ample margin for a correct run of about a thousand
  // requests, even with the gaps and stalls below.
  localparam int CYCLE_LIMIT = 1_500_000;
  localparam int RANDOM_PER_PHASE = 330;
  // Room for expected results; only a couple are ever outstanding.
  localparam int EXPECT_DEPTH = 16;

  logic                          clk = 1'b0;
  logic                          rst = 1'b1;
  logic                          frame_valid = 1'b0;
  logic                          frame_stall;
  logic [atrm_pkg::SAMPLE_W-1:0] frame_time = '0;
  logic                          filtered_valid;
  logic                          filtered_stall = 1'b0;
  logic [atrm_pkg::SAMPLE_W-1:0] filtered_time;

  average_then_running_median_filter uut (
    .clk            (clk),
    .rst            (rst),
    .frame_valid    (frame_valid),
    .frame_stall    (frame_stall),
    .frame_time     (frame_time),
    .filtered_valid (filtered_valid),
    .filtered_stall (filtered_stall),
    .filtered_time  (filtered_time)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Expected filtered times, oldest first, in a small circular store. Only
  // the stimulus side advances expect_written and only the checker advances
  // expect_checked. Also the failure tally.
  logic [atrm_pkg::SAMPLE_W-1:0] expected_times [EXPECT_DEPTH];
  int                            expect_written = 0;
  int                            expect_checked = 0;
  int                            mismatch_count = 0;

  // Idle rates in percent per cycle for each side, changed by phase.
  int sender_idle_pct = 18;
  int receiver_idle_pct = 52;

  // A request from the stimulus side for one long receiver hold-off.
  bit hold_pending = 1'b0;
  int hold_left = 0;

  // ---------------------------------------------------------------------
  // Predictor state: the sample ring with its running total, and the held
  // means kept in ascending order, each tagged with its age (0 = newest).
  // Everything starts empty, matching the state right after reset.
  // ---------------------------------------------------------------------
  logic [atrm_pkg::SAMPLE_W-1:0] sample_ring [atrm_pkg::AVG_WIN];
  int                            ring_slot = 0;
  int                            ring_count = 0;
  logic [atrm_pkg::SUM_W-1:0]    ring_total = '0;
  logic [atrm_pkg::SAMPLE_W-1:0] sorted_means [atrm_pkg::MED_WIN];
  int                            mean_ages [atrm_pkg::MED_WIN];
  int                            means_held = 0;

  // Pushes one sample through both filter stages and returns the expected
  // filtered time for it.
  function automatic logic [atrm_pkg::SAMPLE_W-1:0] predict_filtered_time(
      input logic [atrm_pkg::SAMPLE_W-1:0] sample);
    logic [atrm_pkg::SAMPLE_W-1:0] mean;
    int                            oldest;
    int                            slot;

    // Moving average: once the ring is full the sample being overwritten
    // leaves the total. The divisor is the number of samples held.
    if (ring_count == atrm_pkg::AVG_WIN) begin
      ring_total = ring_total - sample_ring[ring_slot];
    end else begin
      ring_count++;
    end
    sample_ring[ring_slot] = sample;
    ring_total = ring_total + sample;
    ring_slot = (ring_slot + 1) % atrm_pkg::AVG_WIN;
    mean = atrm_pkg::SAMPLE_W'(ring_total / ring_count);

    // Running median: with a full store the oldest entry goes first and the
    // entries above it close the gap.
    if (means_held == atrm_pkg::MED_WIN) begin
      oldest = 0;
      for (int i = 1; i < means_held; i++) begin
        if (mean_ages[i] > mean_ages[oldest]) oldest = i;
      end
      for (int i = oldest; i + 1 < means_held; i++) begin
        sorted_means[i] = sorted_means[i + 1];
        mean_ages[i] = mean_ages[i + 1];
      end
      means_held--;
    end
    for (int i = 0; i < means_held; i++) mean_ages[i]++;

    // The new mean lands above any equal values already held.
    slot = 0;
    while (slot < means_held && sorted_means[slot] <= mean) slot++;
    for (int i = means_held; i > slot; i--) begin
      sorted_means[i] = sorted_means[i - 1];
      mean_ages[i] = mean_ages[i - 1];
    end
    sorted_means[slot] = mean;
    mean_ages[slot] = 0;
    means_held++;

    // Rank floor(n/2): the upper median when the count is even.
    return sorted_means[means_held / 2];
  endfunction

  // ---------------------------------------------------------------------
  // Directed rows. A known result is typed in only where it is obvious:
  // the first sample passes straight through, and with two held means the
  // upper one is chosen. All other rows go through the predictor.
  // ---------------------------------------------------------------------
  typedef struct packed {
    logic [atrm_pkg::SAMPLE_W-1:0] sample;
    logic                          known_valid;
    logic [atrm_pkg::SAMPLE_W-1:0] known_result;
  } frame_row_t;

  localparam int DIRECTED_ROWS = 21;

  frame_row_t directed_rows [DIRECTED_ROWS] = '{
    '{24'hFFFFFF, 1'b1, 24'hFFFFFF},  // first sample is its own median
    '{24'h000000, 1'b1, 24'hFFFFFF},  // two means: the upper one wins
    '{24'h000000, 1'b0, 24'h000000},
    '{24'h000000, 1'b0, 24'h000000},
    // Eight maximum samples in a row: the ring wraps and the total peaks.
    '{24'hFFFFFF, 1'b0, 24'h000000},
    '{24'hFFFFFF, 1'b0, 24'h000000},
    '{24'hFFFFFF, 1'b0, 24'h000000},
    '{24'hFFFFFF, 1'b0, 24'h000000},
    '{24'hFFFFFF, 1'b0, 24'h000000},
    '{24'hFFFFFF, 1'b0, 24'h000000},
    '{24'hFFFFFF, 1'b0, 24'h000000},
    '{24'hFFFFFF, 1'b0, 24'h000000},
    '{24'h000001, 1'b0, 24'h000000},
    '{24'h800000, 1'b0, 24'h000000},
    '{24'h7FFFFF, 1'b0, 24'h000000},
    '{24'hAAAAAA, 1'b0, 24'h000000},
    '{24'h555555, 1'b0, 24'h000000},
    // Repeated samples in a row.
    '{24'h123456, 1'b0, 24'h000000},
    '{24'h123456, 1'b0, 24'h000000},
    '{24'h123456, 1'b0, 24'h000000},
    '{24'h00003F, 1'b0, 24'h000000}
  };

  // Random frame times: plausible frame durations with jitter, full-range
  // values, repeats, tiny values, near-maximum values and spikes.
  function automatic logic [atrm_pkg::SAMPLE_W-1:0] next_frame_time(
      input logic [atrm_pkg::SAMPLE_W-1:0] previous);
    logic [atrm_pkg::SAMPLE_W-1:0] sample;

    case ($urandom_range(0, 9))
      0, 1, 2: sample = atrm_pkg::SAMPLE_W'($urandom);
      3, 4, 5: sample = atrm_pkg::SAMPLE_W'(24'h3000 + $urandom_range(0, 24'h3000));
      6:       sample = previous;
      7:       sample = atrm_pkg::SAMPLE_W'($urandom_range(0, 15));
      8:       sample = 24'hFFFFFF - atrm_pkg::SAMPLE_W'($urandom_range(0, 15));
      default: sample = atrm_pkg::SAMPLE_W'($urandom_range(24'h10000, 24'h100000));
    endcase
    return sample;
  endfunction

  // Offers one request and returns at the edge where it is accepted. Valid
  // is lowered only when a gap starts, so back-to-back requests keep it high.
  // Now and then a gap is stretched across a whole request's worth of work
  // so that it lands on every step of the block's processing.
  task automatic send_request(input logic [atrm_pkg::SAMPLE_W-1:0] sample,
                              input logic                          known_valid,
                              input logic [atrm_pkg::SAMPLE_W-1:0] known_result);
    logic [atrm_pkg::SAMPLE_W-1:0] predicted;

    if ($urandom_range(0, 99) < sender_idle_pct) begin
      frame_valid <= 1'b0;
      if ($urandom_range(0, 7) == 0) begin
        repeat ($urandom_range(1, ITEM_CYCLES)) @(posedge clk);
      end else begin
        do @(posedge clk); while ($urandom_range(0, 99) < sender_idle_pct);
      end
    end
    frame_valid <= 1'b1;
    frame_time <= sample;
    @(posedge clk);
    while (frame_stall) @(posedge clk);

    predicted = predict_filtered_time(sample);
    expected_times[expect_written % EXPECT_DEPTH] = known_valid ? known_result : predicted;
    expect_written++;
  endtask

  // Runs one phase of random requests. hold_at asks the receiver for its
  // long hold-off at that request while the sender keeps offering, so the
  // block fills up and stalls its input; pause_at makes the sender wait
  // until every expected result has arrived. A negative index skips either.
  task automatic run_random_phase(input int count, input int hold_at,
                                  input int pause_at);
    logic [atrm_pkg::SAMPLE_W-1:0] sample;

    sample = 24'h4000;
    for (int n = 0; n < count; n++) begin
      if (n == hold_at) hold_pending = 1'b1;
      if (n == pause_at) begin
        frame_valid <= 1'b0;
        do @(posedge clk); while (expect_checked != expect_written);
      end
      sample = next_frame_time(sample);
      send_request(sample, 1'b0, '0);
    end
  endtask

  // Receiver: random stalls at the current rate, or a long hold-off counted
  // here when one has been asked for.
  initial begin
    forever begin
      @(posedge clk);
      if (hold_pending) begin
        hold_pending = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        filtered_stall <= 1'b1;
        hold_left--;
      end else begin
        filtered_stall <= ($urandom_range(0, 99) < receiver_idle_pct);
      end
    end
  end

  // Every accepted result is compared with the oldest expectation; a result
  // with nothing waiting is a failure too.
  always @(posedge clk) begin
    logic [atrm_pkg::SAMPLE_W-1:0] wanted;

    if (!rst && filtered_valid && !filtered_stall) begin
      if (expect_checked == expect_written) begin
        $display("%0t: unexpected filtered_time result, expected none, got %h",
                 $time, filtered_time);
        mismatch_count++;
      end else begin
        wanted = expected_times[expect_checked % EXPECT_DEPTH];
        expect_checked++;
        if (filtered_time !== wanted) begin
          $display("%0t: filtered_time mismatch, expected %h, got %h",
                   $time, wanted, filtered_time);
          mismatch_count++;
        end
      end
    end
  end

  // Watchdog on the whole run.
  int cycle_count = 0;

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d results still expected",
               $time, expect_written - expect_checked);
      $display("average_then_running_median_filter verification failed");
      $finish;
    end
  end

  // Stimulus and the end of the run.
  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // Phase one: sender idles lightly, receiver stalls often. The directed
    // rows run here, then random requests with a full drain in the middle.
    sender_idle_pct = 18;
    receiver_idle_pct = 52;
    for (int r = 0; r < DIRECTED_ROWS; r++) begin
      send_request(directed_rows[r].sample, directed_rows[r].known_valid,
                   directed_rows[r].known_result);
    end
    run_random_phase(RANDOM_PER_PHASE, 120, 200);

    // Phase two: the rates swap.
    sender_idle_pct = 52;
    receiver_idle_pct = 18;
    run_random_phase(RANDOM_PER_PHASE, -1, -1);

    // Phase three: neither side idles, and the receiver holds off once while
    // the sender pushes as fast as the block allows.
    sender_idle_pct = 0;
    receiver_idle_pct = 0;
    run_random_phase(RANDOM_PER_PHASE + 10, 150, -1);

    frame_valid <= 1'b0;
    do @(posedge clk); while (expect_checked != expect_written);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatch_count == 0) begin
      $display("average_then_running_median_filter verification clean");
    end else begin
      $display("average_then_running_median_filter verification failed");
    end
    $finish;
  end

endmodule
